/* rtl/stk_pkg.sv */
// ----------------------------------------------------------------------------
// stk_pkg
// Types and constants shared by the down counter timer modules.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned ElapsedWidth = 24;

  // CTRL register bit positions
  localparam int unsigned CtrlEnableBit = 0;
  localparam int unsigned CtrlTickIntBit = 1;
  localparam int unsigned CtrlClkSrcBit = 2;
  localparam int unsigned CtrlFlagBit   = 16;

  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncWrite = 2'd1,
    FuncRead  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    RegCtrl     = 2'd0,
    RegReload   = 2'd1,
    RegCurrent  = 2'd2,
    RegIntCount = 2'd3
  } reg_sel_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [1:0]           reg_select;
    logic [DataWidth-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DataWidth-1:0]    read_data;
    logic                    interrupt;
    logic [ElapsedWidth-1:0] elapsed;
  } result_t;

endpackage

/* rtl/systick_down_counter_timer.sv */
// ----------------------------------------------------------------------------
// systick_down_counter_timer
// Down counter timer behind CTRL, RELOAD, CURRENT and interrupt count
// registers; each word is a tick, a register write or a register read.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------
//  in       | in        | in_valid_i / in_ready_o | func_i reg_select_i
//           |           |                         | write_data_i
//  out      | out       | out_valid_o/out_ready_i | read_data_o interrupt_o
//           |           |                         | elapsed_o
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_one_shot_i
//
// One word per cycle sustained while the output is ready. A word goes from the
// input register through the state update into the result register. A
// stalled output holds the result register; the input register still takes
// one more word. No clearing pass after reset.
// ----------------------------------------------------------------------------
module systick_down_counter_timer import stk_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              func_i,
  input  logic [1:0]              reg_select_i,
  input  logic [DataWidth-1:0]    write_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DataWidth-1:0]    read_data_o,
  output logic                    interrupt_o,
  output logic [ElapsedWidth-1:0] elapsed_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_one_shot_i
);

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    one_shot_q;
  logic    advance;
  logic    in_take;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      one_shot_q  <= 1'b0;
    end else begin
      in_valid_q  <= in_take || (in_valid_q && !advance);
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        one_shot_q <= cfg_one_shot_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.func       <= func_i;
      item_q.reg_select <= reg_select_i;
      item_q.write_data <= write_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  stk_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (item_q),
    .one_shot_i (one_shot_q),
    .result_o   (res_d)
  );

  assign out_valid_o = out_valid_q;
  assign read_data_o = res_q.read_data;
  assign interrupt_o = res_q.interrupt;
  assign elapsed_o   = res_q.elapsed;

  // interrupts come only from ticks, which never return read data
  a_irq_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && interrupt_o |-> read_data_o == '0)
    else $error("interrupt word carries read data");

  // one-shot expiry clears reload and current together
  a_oneshot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && interrupt_o && one_shot_q |-> elapsed_o == '0)
    else $error("one-shot expiry left elapsed nonzero");

  // input only stalls when both registers are full and output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output");

  // a processed word shows up as a valid result next cycle
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed word lost");

endmodule

/* rtl/stk_core.sv */
// ----------------------------------------------------------------------------
// stk_core
// Timer state registers and the combinational update for one word.
// ----------------------------------------------------------------------------
module stk_core import stk_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 24
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  logic    one_shot_i,
  output result_t result_o
);

  logic                     enable_q, enable_d;
  logic                     tick_int_q, tick_int_d;
  logic                     clk_src_q, clk_src_d;
  logic                     flag_q, flag_d;
  logic [COUNTER_WIDTH-1:0] reload_q, reload_d;
  logic [COUNTER_WIDTH-1:0] current_q, current_d;
  logic [DataWidth-1:0]     int_count_q, int_count_d;
  logic [COUNTER_WIDTH-1:0] cur_dec;
  logic [COUNTER_WIDTH-1:0] diff;
  logic [DataWidth-1:0]     rdata;
  logic                     irq;

  always_comb begin
    enable_d    = enable_q;
    tick_int_d  = tick_int_q;
    clk_src_d   = clk_src_q;
    flag_d      = flag_q;
    reload_d    = reload_q;
    current_d   = current_q;
    int_count_d = int_count_q;
    rdata       = '0;
    irq         = 1'b0;
    cur_dec     = current_q - COUNTER_WIDTH'(1);

    unique case (func_e'(item_i.func))
      FuncTick: begin
        if (enable_q) begin
          if (current_q == '0) begin
            current_d = reload_q;
          end else begin
            current_d = cur_dec;
            if (cur_dec == '0) begin
              flag_d = 1'b1;
              if (tick_int_q) begin
                irq         = 1'b1;
                int_count_d = int_count_q + DataWidth'(1);
                // one-shot: stop and clear as the handler would
                if (one_shot_i) begin
                  enable_d   = 1'b0;
                  tick_int_d = 1'b0;
                  reload_d   = '0;
                  current_d  = '0;
                  flag_d     = 1'b0;
                end
              end
            end
          end
        end
      end
      FuncWrite: begin
        unique case (reg_sel_e'(item_i.reg_select))
          RegCtrl: begin
            enable_d   = item_i.write_data[CtrlEnableBit];
            tick_int_d = item_i.write_data[CtrlTickIntBit];
            clk_src_d  = item_i.write_data[CtrlClkSrcBit];
          end
          RegReload:   reload_d = item_i.write_data[COUNTER_WIDTH-1:0];
          RegCurrent: begin
            current_d = '0;
            flag_d    = 1'b0;
          end
          RegIntCount: int_count_d = item_i.write_data;
        endcase
      end
      FuncRead: begin
        unique case (reg_sel_e'(item_i.reg_select))
          RegCtrl: begin
            rdata[CtrlEnableBit]  = enable_q;
            rdata[CtrlTickIntBit] = tick_int_q;
            rdata[CtrlClkSrcBit]  = clk_src_q;
            rdata[CtrlFlagBit]    = flag_q;
            flag_d                = 1'b0;  // flag clears on read
          end
          RegReload:   rdata = DataWidth'(reload_q);
          RegCurrent:  rdata = DataWidth'(current_q);
          RegIntCount: rdata = int_count_q;
        endcase
      end
      default: ;
    endcase

    diff = reload_d - current_d;
  end

  assign result_o.read_data = rdata;
  assign result_o.interrupt = irq;
  assign result_o.elapsed   = ElapsedWidth'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      tick_int_q  <= 1'b0;
      clk_src_q   <= 1'b0;
      flag_q      <= 1'b0;
      reload_q    <= '0;
      current_q   <= '0;
      int_count_q <= '0;
    end else if (step_i) begin
      enable_q    <= enable_d;
      tick_int_q  <= tick_int_d;
      clk_src_q   <= clk_src_d;
      flag_q      <= flag_d;
      reload_q    <= reload_d;
      current_q   <= current_d;
      int_count_q <= int_count_d;
    end
  end

endmodule

/* verif/tb_systick_down_counter_timer.sv */
// ----------------------------------------------------------------------------
// tb_systick_down_counter_timer
// Self-checking bench for the down counter timer. A directed table walks
// reset values, register extremes, the count flag and interrupt count wrap;
// random phases then alternate periodic and one-shot mode, mostly as
// reload/ctrl setup followed by tick runs. Every result word is checked
// field by field against the directed table's pinned values or an in-bench model of the timer registers.
// ----------------------------------------------------------------------------
module tb_systick_down_counter_timer;
  import stk_pkg::*;

  localparam logic [1:0]  FuncUnused    = 2'd3;
  localparam int unsigned NumDirRows    = 27;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned LatencyCycles = 4;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned MaxPrints     = 40;
  localparam int unsigned TimeLimit     = 600000;

  typedef struct packed {
    logic [1:0]  f;
    logic [1:0]  s;
    logic [31:0] d;
    logic        pinned;
    result_t     res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready_o;
  logic [1:0] func, reg_sel;
  logic [DataWidth-1:0] wdata;
  logic out_valid_o, out_ready;
  logic [DataWidth-1:0] read_data_o;
  logic interrupt_o;
  logic [ElapsedWidth-1:0] elapsed_o;
  logic cfg_valid, cfg_ready_o, cfg_one_shot;
  logic hold_off_req;

  // timer model state
  logic        tm_enable, tm_int_en, tm_clk_src, tm_flag, tm_one_shot;
  logic [23:0] tm_reload, tm_current;
  logic [31:0] tm_irq_count;

  result_t     due_results[$];
  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned burst_left;
  dir_row_t    dir_rows[NumDirRows];

  always #1 clk = ~clk;

  systick_down_counter_timer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .func_i         (func),
    .reg_select_i   (reg_sel),
    .write_data_i   (wdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .read_data_o    (read_data_o),
    .interrupt_o    (interrupt_o),
    .elapsed_o      (elapsed_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_one_shot_i (cfg_one_shot)
  );

  function automatic result_t timer_step(logic [1:0] f, logic [1:0] s, logic [31:0] d);
    result_t r;
    r = '0;
    case (f)
      FuncTick: begin
        if (tm_enable) begin
          if (tm_current == 24'd0) begin
            tm_current = tm_reload;
          end else begin
            tm_current = tm_current - 24'd1;
            if (tm_current == 24'd0) begin
              tm_flag = 1'b1;
              if (tm_int_en) begin
                r.interrupt  = 1'b1;
                tm_irq_count = tm_irq_count + 32'd1;
                if (tm_one_shot) begin
                  tm_enable  = 1'b0;
                  tm_int_en  = 1'b0;
                  tm_reload  = '0;
                  tm_current = '0;
                  tm_flag    = 1'b0;
                end
              end
            end
          end
        end
      end
      FuncWrite: begin
        case (s)
          RegCtrl: begin
            tm_enable  = d[CtrlEnableBit];
            tm_int_en  = d[CtrlTickIntBit];
            tm_clk_src = d[CtrlClkSrcBit];
          end
          RegReload:  tm_reload = d[23:0];
          RegCurrent: begin
            tm_current = '0;
            tm_flag    = 1'b0;
          end
          default:    tm_irq_count = d;
        endcase
      end
      FuncRead: begin
        case (s)
          RegCtrl: begin
            r.read_data[CtrlEnableBit]  = tm_enable;
            r.read_data[CtrlTickIntBit] = tm_int_en;
            r.read_data[CtrlClkSrcBit]  = tm_clk_src;
            r.read_data[CtrlFlagBit]    = tm_flag;
            tm_flag = 1'b0;
          end
          RegReload:  r.read_data = {8'd0, tm_reload};
          RegCurrent: r.read_data = {8'd0, tm_current};
          default:    r.read_data = tm_irq_count;
        endcase
      end
      default: ;
    endcase
    r.elapsed = tm_reload - tm_current;
    return r;
  endfunction

  function automatic dir_row_t row(logic [1:0] f, logic [1:0] s, logic [31:0] d,
                                   int unsigned pinned, logic [31:0] rd,
                                   int unsigned irq, logic [23:0] el);
    dir_row_t w;
    w.f = f;
    w.s = s;
    w.d = d;
    w.pinned = 1'(pinned);
    w.res.read_data = rd;
    w.res.interrupt = 1'(irq);
    w.res.elapsed = el;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < MaxPrints) begin
      $display("mismatch %s: got %h want %h", what, got, want);
    end
    fail_count++;
  endtask

  task automatic idle(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(logic [1:0] f, logic [1:0] s, logic [31:0] d,
                           logic pinned = 1'b0, result_t pinned_res = '0);
    result_t r;
    in_valid <= 1'b1;
    func     <= f;
    reg_sel  <= s;
    wdata    <= d;
    do @(posedge clk); while (!in_ready_o);
    r = timer_step(f, s, d);
    due_results.push_back(pinned ? pinned_res : r);
    items_sent++;
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic offer(logic [1:0] f, logic [1:0] s, logic [31:0] d);
    send_word(f, s, d);
    pace();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  task automatic set_one_shot(logic v);
    cfg_valid    <= 1'b1;
    cfg_one_shot <= v;
    do @(posedge clk); while (!cfg_ready_o);
    tm_one_shot = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_noise();
    logic [1:0]  f;
    logic [31:0] d;
    f = ($urandom_range(0, 24) == 0) ? FuncUnused : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0:       d = '0;
      1:       d = '1;
      2:       d = 32'hFFFF_FFFE;
      default: d = $urandom;
    endcase
    offer(f, 2'($urandom_range(0, 3)), d);
  endtask

  // reload/ctrl setup, then a run of ticks with the odd read mixed in
  task automatic offer_sequence();
    logic [31:0] rl;
    logic [31:0] ctl;
    int unsigned n;
    case ($urandom_range(0, 11))
      0:       rl = $urandom;
      1:       rl = $urandom & 32'hFF00_0000;
      2:       rl = 32'hFFFF_FFFF;
      default: rl = ($urandom & 32'hFF00_0000) | $urandom_range(1, 12);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      offer(FuncWrite, RegIntCount, 32'hFFFF_FFFF - $urandom_range(0, 3));
    end
    offer(FuncWrite, RegReload, rl);
    if ($urandom_range(0, 1) == 1) begin
      offer(FuncWrite, RegCurrent, $urandom);
    end
    ctl = $urandom;
    ctl[CtrlEnableBit]  = ($urandom_range(0, 9) != 0);
    ctl[CtrlTickIntBit] = ($urandom_range(0, 3) != 0);
    offer(FuncWrite, RegCtrl, ctl);
    n = $urandom_range(2, 30);
    repeat (n) begin
      if ($urandom_range(0, 6) == 0) begin
        offer(FuncRead, 2'($urandom_range(0, 3)), $urandom);
      end else begin
        offer(FuncTick, 2'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word", read_data_o, '0);
      end else begin
        want = due_results.pop_front();
        if (read_data_o !== want.read_data) begin
          report_mismatch("read_data", read_data_o, want.read_data);
        end
        if (interrupt_o !== want.interrupt) begin
          report_mismatch("interrupt", 32'(interrupt_o), 32'(want.interrupt));
        end
        if (elapsed_o !== want.elapsed) begin
          report_mismatch("elapsed", 32'(elapsed_o), 32'(want.elapsed));
        end
      end
    end
  end

  // receiver: stall pattern changes mode now and then; long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned cyc;
    logic        hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_req === 1'b1 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    #(TimeLimit);
    $display("tb_systick_down_counter_timer NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned target;
    logic        pressed;
    logic        mode_bit;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    func         <= FuncTick;
    reg_sel      <= RegCtrl;
    wdata        <= '0;
    cfg_valid    <= 1'b0;
    cfg_one_shot <= 1'b0;
    hold_off_req <= 1'b0;
    tm_enable    = 1'b0;
    tm_int_en    = 1'b0;
    tm_clk_src   = 1'b0;
    tm_flag      = 1'b0;
    tm_one_shot  = 1'b0;
    tm_reload    = '0;
    tm_current   = '0;
    tm_irq_count = '0;
    items_sent   = 0;
    fail_count   = 0;
    burst_left   = 0;
    pressed      = 1'b0;

    dir_rows = '{
      row(FuncRead,   RegCtrl,     32'h0,         1, 32'h0,       0, 24'h0),
      row(FuncRead,   RegIntCount, 32'h0,         1, 32'h0,       0, 24'h0),
      row(FuncTick,   RegCtrl,     32'hFFFF_FFFF, 1, 32'h0,       0, 24'h0),  // disabled
      row(FuncWrite,  RegReload,   32'hFFFF_FFFF, 1, 32'h0,       0, 24'hFF_FFFF),
      row(FuncRead,   RegReload,   32'h0,         1, 32'h00FF_FFFF, 0, 24'hFF_FFFF),
      row(FuncWrite,  RegCurrent,  32'h1234_5678, 1, 32'h0,       0, 24'hFF_FFFF),
      row(FuncWrite,  RegReload,   32'h3,         1, 32'h0,       0, 24'h3),
      row(FuncWrite,  RegCtrl,     32'hFFFF_FFFF, 1, 32'h0,       0, 24'h3),
      row(FuncRead,   RegCtrl,     32'h0,         1, 32'h7,       0, 24'h3),
      row(FuncTick,   RegCtrl,     32'h0,         1, 32'h0,       0, 24'h0),  // load
      row(FuncTick,   RegCtrl,     32'h0,         1, 32'h0,       0, 24'h1),
      row(FuncTick,   RegCtrl,     32'h0,         1, 32'h0,       0, 24'h2),
      row(FuncTick,   RegCtrl,     32'h0,         1, 32'h0,       1, 24'h3),  // hits zero
      row(FuncRead,   RegCtrl,     32'h0,         1, 32'h0001_0007, 0, 24'h3),
      row(FuncRead,   RegCtrl,     32'h0,         1, 32'h7,       0, 24'h3),  // flag cleared
      row(FuncRead,   RegIntCount, 32'h0,         1, 32'h1,       0, 24'h3),
      row(FuncWrite,  RegIntCount, 32'hFFFF_FFFF, 1, 32'h0,       0, 24'h3),
      row(FuncTick,   RegReload,   32'h0,         0, 32'h0,       0, 24'h0),
      row(FuncTick,   RegCurrent,  32'h0,         0, 32'h0,       0, 24'h0),
      row(FuncTick,   RegIntCount, 32'h0,         0, 32'h0,       0, 24'h0),
      row(FuncTick,   RegCtrl,     32'h0,         0, 32'h0,       0, 24'h0),  // count wraps
      row(FuncRead,   RegIntCount, 32'h0,         1, 32'h0,       0, 24'h3),
      row(FuncWrite,  RegReload,   32'h0,         0, 32'h0,       0, 24'h0),
      row(FuncWrite,  RegCtrl,     32'h1,         0, 32'h0,       0, 24'h0),
      row(FuncTick,   RegCtrl,     32'h0,         0, 32'h0,       0, 24'h0),  // zero reload
      row(FuncRead,   RegCurrent,  32'h0,         0, 32'h0,       0, 24'h0),
      row(FuncUnused, RegCtrl,     32'hFFFF_FFFF, 1, 32'h0,       0, 24'h0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirRows; i++) begin
      send_word(dir_rows[i].f, dir_rows[i].s, dir_rows[i].d,
                dir_rows[i].pinned, dir_rows[i].res);
      pace();
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      mode_bit = (p == NumPhases - 1) ? 1'($urandom_range(0, 1)) : (p % 2 == 0);
      set_one_shot(mode_bit);
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) begin
        if (p == 1 && !pressed && items_sent + ItemsPerPhase / 2 > target) begin
          // receiver holds off while words keep coming back to back
          hold_off_req <= 1'b1;
          burst_left = 80;
          pressed = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          offer_sequence();
        end else begin
          repeat ($urandom_range(1, 4)) offer_noise();
        end
        if ($urandom_range(0, 40) == 0) begin
          settle();
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_systick_down_counter_timer OK");
    end else begin
      $display("tb_systick_down_counter_timer NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/stk_pkg.sv
rtl/stk_core.sv
rtl/systick_down_counter_timer.sv
verif/tb_systick_down_counter_timer.sv
